[design/rrw_pkg.sv]
`timescale 1ns / 1ps

package rrw_pkg;

    // command codes on s_tuser
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_CANVAS_WIDTH    = 2'd0;
    localparam logic [1:0] REG_CANVAS_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_BACKGROUND_CHAR = 2'd2;

    localparam logic [9:0] RESET_CANVAS_WIDTH    = 10'd512;
    localparam logic [9:0] RESET_CANVAS_HEIGHT   = 10'd512;
    localparam logic [7:0] RESET_BACKGROUND_CHAR = 8'd32;

    localparam logic [7:0] LETTER_FILLED  = 8'h52;  // 'R'
    localparam logic [7:0] LETTER_OUTLINE = 8'h72;  // 'r'

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // signed cell coordinate, wide enough for any edge and any clipped index
    typedef logic signed [13:0] coord_t;

    typedef enum logic [1:0] {
        JOB_CLEAR,
        JOB_DRAW,
        JOB_READ,
        JOB_REPLY
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic        status;
        logic        fill;
        coord_t      r0;
        coord_t      r1;
        coord_t      c0;
        coord_t      c1;
        logic [7:0]  ch;
        logic [8:0]  read_row;
        logic [8:0]  read_col;
    } job_t;

    typedef struct packed {
        logic [9:0] width;
        logic [9:0] height;
        logic [7:0] background;
    } canvas_cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SWEEP,
        BK_EMIT
    } back_state_t;

endpackage

[design/rectangle_raster_writer_top.sv]
`timescale 1ns / 1ps

// Byte canvas rasterizer. Each s_ transaction carries one command (clear, draw
// rectangle, read cell) and yields exactly one m_ transaction, in order. The
// canvas memory has one write port and the sweep visits one cell per cycle,
// which sets the rate: a clear sweeps height*width cells, a draw the clipped
// bounding box area (rows*columns, outline or filled alike), and a read, a
// rejected draw or an empty draw sweeps no cells. The sweep engine hands each
// reply to its output register before it takes the next command. Commands are
// decoded and queued up to five deep (decode register plus a four-entry queue)
// ahead of the sweep engine, so the input side keeps accepting while a long
// fill runs. Canvas contents are undefined after reset until a clear or a draw
// writes them; there is no reset sweep.
// Configuration writes are taken any cycle but must only be issued while no
// command is outstanding.
module rectangle_raster_writer_top #(
    parameter int MAX_COLUMNS = 512,
    parameter int MAX_ROWS    = 512
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [18:0] rect_x, [37:19] rect_y, [56:38] rect_width, [75:57] rect_height,
    // [83:76] shape_letter, [91:84] draw_char, [100:92] read_row,
    // [109:101] read_col, [111:110] zero
    input  logic [111:0] s_tdata,
    // [1:0] command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] cell_value
    output logic [7:0]   m_tdata,
    // [0] status
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [9:0]   cfg_data
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;

    logic [9:0] width_reg, width_next;
    logic [9:0] height_reg, height_next;
    logic [7:0] bg_reg, bg_next;

    rrw_pkg::canvas_cfg_t canvas_cfg;

    logic          fr_valid, fr_ready, q_valid, q_ready;
    rrw_pkg::job_t fr_job, q_job;

    logic              ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
    logic [7:0]        ram_wr_data, ram_rd_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        bg_next     = bg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rrw_pkg::REG_CANVAS_WIDTH:    width_next  = cfg_data;
                rrw_pkg::REG_CANVAS_HEIGHT:   height_next = cfg_data;
                rrw_pkg::REG_BACKGROUND_CHAR: bg_next     = cfg_data[7:0];
                default: ;
            endcase
        end

        // zero acts as one, anything past the maximum as the maximum
        if (width_reg == 10'd0) begin
            canvas_cfg.width = 10'd1;
        end else if ({3'b0, width_reg} > 13'(MAX_COLUMNS)) begin
            canvas_cfg.width = 10'(MAX_COLUMNS);
        end else begin
            canvas_cfg.width = width_reg;
        end
        if (height_reg == 10'd0) begin
            canvas_cfg.height = 10'd1;
        end else if ({3'b0, height_reg} > 13'(MAX_ROWS)) begin
            canvas_cfg.height = 10'(MAX_ROWS);
        end else begin
            canvas_cfg.height = height_reg;
        end
        canvas_cfg.background = bg_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= rrw_pkg::RESET_CANVAS_WIDTH;
            height_reg <= rrw_pkg::RESET_CANVAS_HEIGHT;
            bg_reg     <= rrw_pkg::RESET_BACKGROUND_CHAR;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            bg_reg     <= bg_next;
        end
    end

    rrw_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .command      (s_tuser),
        .rect_x       (s_tdata[18:0]),
        .rect_y       (s_tdata[37:19]),
        .rect_width   (s_tdata[56:38]),
        .rect_height  (s_tdata[75:57]),
        .shape_letter (s_tdata[83:76]),
        .draw_char    (s_tdata[91:84]),
        .read_row     (s_tdata[100:92]),
        .read_col     (s_tdata[109:101]),
        .job_valid    (fr_valid),
        .job_ready    (fr_ready),
        .job          (fr_job)
    );

    rrw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_job    (fr_job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_job   (q_job)
    );

    rrw_back #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (canvas_cfg),
        .job_valid   (q_valid),
        .job_ready   (q_ready),
        .job         (q_job),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_status  (m_tuser[0]),
        .res_cell    (m_tdata)
    );

    rrw_ram #(
        .DATA_W (8),
        .ADDR_W (ADDR_W)
    ) u_canvas (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

`ifndef SYNTH
    a_no_rd_wr_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_wr_en && ram_rd_en))
        else $error("canvas read and write in the same cycle");

    a_wr_row_in_canvas: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (ram_wr_addr[ADDR_W-1:COL_W] < canvas_cfg.height))
        else $error("canvas write below the last row");

    a_wr_col_in_canvas: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (ram_wr_addr[COL_W-1:0] < canvas_cfg.width))
        else $error("canvas write right of the last column");
`endif

endmodule

[design/rrw_ram.sv]
`timescale 1ns / 1ps

module rrw_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 18
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/rrw_front.sv]
`timescale 1ns / 1ps

module rrw_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic signed [18:0] rect_x,
    input  logic signed [18:0] rect_y,
    input  logic signed [18:0] rect_width,
    input  logic signed [18:0] rect_height,
    input  logic [7:0]         shape_letter,
    input  logic [7:0]         draw_char,
    input  logic [8:0]         read_row,
    input  logic [8:0]         read_col,
    output logic               job_valid,
    input  logic               job_ready,
    output rrw_pkg::job_t      job
);

    logic          job_valid_reg, job_valid_next;
    rrw_pkg::job_t job_reg, job_next;

    logic signed [19:0] x_w, y_w, x_far, y_far, x_up, y_up;
    logic               letter_ok, size_ok;

    always_comb begin
        x_w   = 20'(rect_x);
        y_w   = 20'(rect_y);
        x_far = x_w + 20'(rect_width);
        y_far = y_w + 20'(rect_height);
        // ceil of Q.8 is floor of (v + 255)
        x_up  = x_w + 20'sd255;
        y_up  = y_w + 20'sd255;

        letter_ok = (shape_letter == rrw_pkg::LETTER_FILLED) ||
                    (shape_letter == rrw_pkg::LETTER_OUTLINE);
        size_ok   = !rect_width[18] && (rect_width != 19'sd0) &&
                    !rect_height[18] && (rect_height != 19'sd0);

        job_next          = job_reg;
        job_valid_next    = job_valid_reg;
        in_ready          = !job_valid_reg || job_ready;

        if (job_valid_reg && job_ready) begin
            job_valid_next = 1'b0;
        end

        if (in_valid && in_ready) begin
            job_valid_next    = 1'b1;
            job_next.status   = 1'b0;
            job_next.fill     = (shape_letter == rrw_pkg::LETTER_FILLED);
            job_next.c0       = 14'(x_up >>> 8);
            job_next.c1       = 14'(x_far >>> 8);
            job_next.r0       = 14'(y_up >>> 8);
            job_next.r1       = 14'(y_far >>> 8);
            job_next.ch       = draw_char;
            job_next.read_row = read_row;
            job_next.read_col = read_col;
            unique case (command)
                rrw_pkg::CMD_CLEAR: job_next.kind = rrw_pkg::JOB_CLEAR;
                rrw_pkg::CMD_DRAW: begin
                    if (letter_ok && size_ok) begin
                        job_next.kind = rrw_pkg::JOB_DRAW;
                    end else begin
                        job_next.kind   = rrw_pkg::JOB_REPLY;
                        job_next.status = 1'b1;
                    end
                end
                rrw_pkg::CMD_READ: job_next.kind = rrw_pkg::JOB_READ;
                default: job_next.kind = rrw_pkg::JOB_REPLY;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
        end
        job_reg <= job_next;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

[design/rrw_queue.sv]
`timescale 1ns / 1ps

module rrw_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  rrw_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output rrw_pkg::job_t out_job
);

    rrw_pkg::job_t                mem_reg [rrw_pkg::QUEUE_DEPTH];
    logic [rrw_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [rrw_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [rrw_pkg::QPTR_W:0]     count_reg, count_next;
    logic                         push, pop;

    always_comb begin
        in_ready  = (count_reg != (rrw_pkg::QPTR_W + 1)'(rrw_pkg::QUEUE_DEPTH));
        out_valid = (count_reg != '0);
        push      = in_valid && in_ready;
        pop       = out_valid && out_ready;

        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

    assign out_job = mem_reg[rd_ptr_reg];

endmodule

[design/rrw_back.sv]
`timescale 1ns / 1ps

module rrw_back #(
    parameter int ROW_W = 9,
    parameter int COL_W = 9
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rrw_pkg::canvas_cfg_t     cfg,
    input  logic                     job_valid,
    output logic                     job_ready,
    input  rrw_pkg::job_t            job,
    output logic                     ram_wr_en,
    output logic [ROW_W+COL_W-1:0]   ram_wr_addr,
    output logic [7:0]               ram_wr_data,
    output logic                     ram_rd_en,
    output logic [ROW_W+COL_W-1:0]   ram_rd_addr,
    input  logic [7:0]               ram_rd_data,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic                     res_status,
    output logic [7:0]               res_cell
);

    rrw_pkg::back_state_t state_reg, state_next;

    rrw_pkg::coord_t row_reg, row_next, col_reg, col_next;
    rrw_pkg::coord_t cs_reg, cs_next, ce_reg, ce_next, re_reg, re_next;
    rrw_pkg::coord_t r0_reg, r0_next, r1_reg, r1_next;
    rrw_pkg::coord_t c0_reg, c0_next, c1_reg, c1_next;
    logic            fill_reg, fill_next;
    logic [7:0]      ch_reg, ch_next;
    logic            status_reg, status_next;
    logic            from_ram_reg, from_ram_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_status_reg, out_status_next;
    logic [7:0]      out_cell_reg, out_cell_next;

    rrw_pkg::coord_t h_c, w_c, h_m1, w_m1, rs, re, cs, ce;
    logic [12:0]     rr_ext, cc_ext;
    logic            read_hit, on_edge;

    always_comb begin
        h_c    = rrw_pkg::coord_t'({4'b0, cfg.height});
        w_c    = rrw_pkg::coord_t'({4'b0, cfg.width});
        h_m1   = h_c - 14'sd1;
        w_m1   = w_c - 14'sd1;
        // clip the rectangle to the canvas
        rs     = job.r0[13] ? 14'sd0 : job.r0;
        re     = (job.r1 > h_m1) ? h_m1 : job.r1;
        cs     = job.c0[13] ? 14'sd0 : job.c0;
        ce     = (job.c1 > w_m1) ? w_m1 : job.c1;
        rr_ext = {4'b0, job.read_row};
        cc_ext = {4'b0, job.read_col};
        read_hit = ({1'b0, job.read_row} < cfg.height) &&
                   ({1'b0, job.read_col} < cfg.width);
        on_edge  = (row_reg == r0_reg) || (row_reg == r1_reg) ||
                   (col_reg == c0_reg) || (col_reg == c1_reg);

        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        cs_next         = cs_reg;
        ce_next         = ce_reg;
        re_next         = re_reg;
        r0_next         = r0_reg;
        r1_next         = r1_reg;
        c0_next         = c0_reg;
        c1_next         = c1_reg;
        fill_next       = fill_reg;
        ch_next         = ch_reg;
        status_next     = status_reg;
        from_ram_next   = from_ram_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_cell_next   = out_cell_reg;

        job_ready   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = {row_reg[ROW_W-1:0], col_reg[COL_W-1:0]};
        ram_wr_data = ch_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = {rr_ext[ROW_W-1:0], cc_ext[COL_W-1:0]};

        if (out_valid_reg && res_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rrw_pkg::BK_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    status_next   = job.status;
                    from_ram_next = 1'b0;
                    state_next    = rrw_pkg::BK_EMIT;
                    unique case (job.kind)
                        rrw_pkg::JOB_CLEAR: begin
                            row_next   = 14'sd0;
                            col_next   = 14'sd0;
                            cs_next    = 14'sd0;
                            ce_next    = w_m1;
                            re_next    = h_m1;
                            fill_next  = 1'b1;
                            ch_next    = cfg.background;
                            state_next = rrw_pkg::BK_SWEEP;
                        end
                        rrw_pkg::JOB_DRAW: begin
                            row_next  = rs;
                            col_next  = cs;
                            cs_next   = cs;
                            ce_next   = ce;
                            re_next   = re;
                            r0_next   = job.r0;
                            r1_next   = job.r1;
                            c0_next   = job.c0;
                            c1_next   = job.c1;
                            fill_next = job.fill;
                            ch_next   = job.ch;
                            if (rs <= re && cs <= ce) begin
                                state_next = rrw_pkg::BK_SWEEP;
                            end
                        end
                        rrw_pkg::JOB_READ: begin
                            // data shows up on the port while in BK_EMIT
                            ram_rd_en     = read_hit;
                            from_ram_next = read_hit;
                        end
                        rrw_pkg::JOB_REPLY: begin
                        end
                    endcase
                end
            end
            rrw_pkg::BK_SWEEP: begin
                ram_wr_en = fill_reg || on_edge;
                if (col_reg == ce_reg) begin
                    col_next = cs_reg;
                    row_next = row_reg + 14'sd1;
                    if (row_reg == re_reg) begin
                        state_next = rrw_pkg::BK_EMIT;
                    end
                end else begin
                    col_next = col_reg + 14'sd1;
                end
            end
            rrw_pkg::BK_EMIT: begin
                if (!out_valid_reg || res_ready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_cell_next   = from_ram_reg ? ram_rd_data : 8'd0;
                    state_next      = rrw_pkg::BK_IDLE;
                end
            end
            default: state_next = rrw_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rrw_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        row_reg        <= row_next;
        col_reg        <= col_next;
        cs_reg         <= cs_next;
        ce_reg         <= ce_next;
        re_reg         <= re_next;
        r0_reg         <= r0_next;
        r1_reg         <= r1_next;
        c0_reg         <= c0_next;
        c1_reg         <= c1_next;
        fill_reg       <= fill_next;
        ch_reg         <= ch_next;
        status_reg     <= status_next;
        from_ram_reg   <= from_ram_next;
        out_status_reg <= out_status_next;
        out_cell_reg   <= out_cell_next;
    end

    assign res_valid  = out_valid_reg;
    assign res_status = out_status_reg;
    assign res_cell   = out_cell_reg;

endmodule
